FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge; off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int PREFIX_BYTES       = 4;
    localparam int BODY_HEADER_BYTES  = 12;
    localparam int PAYLOAD_COUNT_BITS = 16;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROL_TYPE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SERIAL_TYPE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROL_MAX  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SERIAL_MAX   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_MAX    = 3'd4;

    // configuration reset values
    localparam logic [7:0]  RST_CONTROL_TYPE = 8'd1;
    localparam logic [7:0]  RST_SERIAL_TYPE  = 8'd2;
    localparam logic [15:0] RST_CONTROL_MAX  = 16'd4096;
    localparam logic [15:0] RST_SERIAL_MAX   = 16'd1024;
    localparam logic [16:0] RST_FRAME_MAX    = 17'd65547;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_BAD_LEN = 2'd2,
        EV_BAD_HDR = 2'd3
    } t_event;

    // one result request between front, queue and back
    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [7:0]  kind;
        logic [63:0] seq;
        logic [15:0] plen;
        logic        last;
    } t_cmd;

endpackage

FILE: src/tsd_front.sv
// ----------------------------------------------------------------------------
// tsd_front
// Byte parser: length prefix, body header checks and payload counting.
// ----------------------------------------------------------------------------
module tsd_front
    import tsd_pkg::*;
#(
    parameter int PAYLOAD_COUNT_BITS = tsd_pkg::PAYLOAD_COUNT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_take,
    input  logic [7:0]                i_rx_byte,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    localparam int PCB = PAYLOAD_COUNT_BITS;
    localparam int PLW = (PCB > 16) ? PCB : 16;
    localparam logic [3:0]  PRE_LAST = 4'(PREFIX_BYTES - 1);
    localparam logic [3:0]  HDR_LAST = 4'(BODY_HEADER_BYTES - 1);
    localparam logic [32:0] LEN_CAP  =
        33'(BODY_HEADER_BYTES) + ((33'd1 << PCB) - 33'd1);

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [3:0]     r_hpos, n_hpos;
    logic [31:0]    r_len, n_len;
    logic [7:0]     r_type, n_type;
    logic           r_fault, n_fault;
    logic [63:0]    r_seq, n_seq;
    logic [PCB-1:0] r_left, n_left;

    logic [7:0]  r_ctl_type, r_ser_type;
    logic [15:0] r_ctl_max, r_ser_max;
    logic [16:0] r_frame_max;

    logic [PCB-1:0] w_plen;
    logic [PLW-1:0] w_plen_x;
    logic           w_is_ser, w_is_ctl, w_hdr_bad;
    logic [32:0]    w_frame_max_x, w_lim;

    assign w_plen   = r_len[PCB-1:0] - PCB'(BODY_HEADER_BYTES);
    assign w_plen_x = PLW'(w_plen);
    assign w_is_ser = (r_type == r_ser_type);
    assign w_is_ctl = (r_type == r_ctl_type);
    assign w_hdr_bad = !(w_is_ser || w_is_ctl)
        || (w_is_ser && ((w_plen == '0) || (w_plen_x > PLW'(r_ser_max))))
        || (w_is_ctl && (w_plen_x > PLW'(r_ctl_max)));

    assign w_frame_max_x = 33'(r_frame_max);
    assign w_lim = (w_frame_max_x > LEN_CAP) ? LEN_CAP : w_frame_max_x;

    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_len   = r_len;
        n_type  = r_type;
        n_fault = r_fault;
        n_seq   = r_seq;
        n_left  = r_left;
        o_push  = 1'b0;
        o_cmd.ev         = EV_PAYLOAD;
        o_cmd.data       = i_rx_byte;
        o_cmd.kind       = r_type;
        o_cmd.seq        = r_seq;
        o_cmd.plen       = 16'(w_plen);
        o_cmd.last       = 1'b0;
        if (i_take) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hpos == 4'd0) begin
                        n_type = i_rx_byte;
                    end else if (r_hpos <= 4'd3) begin
                        if (i_rx_byte != 8'd0) begin
                            n_fault = 1'b1;
                        end
                    end else begin
                        n_seq = {r_seq[55:0], i_rx_byte};
                    end
                    n_hpos = r_hpos + 4'd1;
                    if (r_hpos == HDR_LAST) begin
                        n_hpos  = 4'd0;
                        n_fault = r_fault || w_hdr_bad;
                        if (w_plen == '0) begin
                            // empty frame: report now, back to prefix
                            n_phase    = PH_PREFIX;
                            o_push     = 1'b1;
                            o_cmd.ev   = n_fault ? EV_BAD_HDR : EV_EMPTY;
                            o_cmd.seq  = n_seq;
                            o_cmd.plen = 16'd0;
                            o_cmd.last = 1'b1;
                        end else begin
                            n_left  = w_plen;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_left = r_left - PCB'(1);
                    if (n_left == '0) begin
                        n_phase = PH_PREFIX;
                    end
                    if (!r_fault) begin
                        o_push     = 1'b1;
                        o_cmd.last = (n_left == '0);
                    end else if (n_left == '0) begin
                        // drop a bad frame, report once on its last byte
                        o_push     = 1'b1;
                        o_cmd.ev   = EV_BAD_HDR;
                        o_cmd.last = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_PREFIX;
                    n_len   = {r_len[23:0], i_rx_byte};
                    n_hpos  = r_hpos + 4'd1;
                    if (r_hpos == PRE_LAST) begin
                        n_hpos = 4'd0;
                        if ((n_len < 32'(BODY_HEADER_BYTES)) || (33'(n_len) > w_lim)) begin
                            // resync from the next byte
                            n_len      = 32'd0;
                            o_push     = 1'b1;
                            o_cmd.ev   = EV_BAD_LEN;
                            o_cmd.last = 1'b1;
                        end else begin
                            n_phase = PH_HEADER;
                            n_type  = 8'd0;
                            n_fault = 1'b0;
                            n_seq   = 64'd0;
                            n_left  = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_hpos      <= 4'd0;
            r_len       <= 32'd0;
            r_type      <= 8'd0;
            r_fault     <= 1'b0;
            r_seq       <= 64'd0;
            r_left      <= '0;
            r_ctl_type  <= RST_CONTROL_TYPE;
            r_ser_type  <= RST_SERIAL_TYPE;
            r_ctl_max   <= RST_CONTROL_MAX;
            r_ser_max   <= RST_SERIAL_MAX;
            r_frame_max <= RST_FRAME_MAX;
        end else begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_len   <= n_len;
            r_type  <= n_type;
            r_fault <= n_fault;
            r_seq   <= n_seq;
            r_left  <= n_left;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CONTROL_TYPE: r_ctl_type  <= i_cfg_data[7:0];
                    CFG_SERIAL_TYPE:  r_ser_type  <= i_cfg_data[7:0];
                    CFG_CONTROL_MAX:  r_ctl_max   <= i_cfg_data[15:0];
                    CFG_SERIAL_MAX:   r_ser_max   <= i_cfg_data[15:0];
                    CFG_FRAME_MAX:    r_frame_max <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: src/tsd_queue.sv
// ----------------------------------------------------------------------------
// tsd_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module tsd_queue
    import tsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/tsd_back.sv
// ----------------------------------------------------------------------------
// tsd_back
// Output stage: formats queued results and holds them until taken.
// ----------------------------------------------------------------------------
module tsd_back
    import tsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_out
);

    logic r_valid;
    t_cmd r_out;
    t_cmd w_fmt;

    assign o_q_pop     = i_q_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    always_comb begin
        w_fmt = i_q_cmd;
        // only payload events carry a data byte
        if (i_q_cmd.ev != EV_PAYLOAD) begin
            w_fmt.data = 8'd0;
        end
        // a bad length has no frame context
        if (i_q_cmd.ev == EV_BAD_LEN) begin
            w_fmt.kind       = 8'd0;
            w_fmt.seq        = 64'd0;
            w_fmt.plen       = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= w_fmt;
        end
    end

endmodule

FILE: src/typed_sequenced_deframer.sv
// ----------------------------------------------------------------------------
// typed_sequenced_deframer
// Splits a received byte stream into length-prefixed, typed, sequenced frames.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while input ready is high. The parser writes a
// result into the result queue at the edge that accepts the byte causing it,
// and the result moves into the output register once that register is empty
// or its result is being taken. Input ready drops only when the
// QUEUE_DEPTH-entry result queue is full, which happens only while the output
// side holds off. Configuration writes are taken in any cycle.
module typed_sequenced_deframer
    import tsd_pkg::*;
#(
    parameter int PAYLOAD_COUNT_BITS = tsd_pkg::PAYLOAD_COUNT_BITS,
    parameter int QUEUE_DEPTH        = tsd_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_rx_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_event_res,
    output logic [7:0]                o_payload_byte,
    output logic [7:0]                o_frame_kind,
    output logic [63:0]               o_sequence_res,
    output logic [15:0]               o_payload_length,
    output logic                      o_last
);

    logic w_full, w_take, w_push, w_q_valid, w_pop;
    t_cmd w_push_cmd, w_q_cmd, w_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !w_full;
    assign w_take      = i_in_valid && o_in_ready;

    tsd_front #(
        .PAYLOAD_COUNT_BITS(PAYLOAD_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_rx_byte   (i_rx_byte),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    tsd_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    tsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (w_out)
    );

    assign o_event_res      = w_out.ev;
    assign o_payload_byte   = w_out.data;
    assign o_frame_kind     = w_out.kind;
    assign o_sequence_res   = w_out.seq;
    assign o_payload_length = w_out.plen;
    assign o_last           = w_out.last;

endmodule

FILE: src/tsd_checker.sv
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level assertions on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsd_checker
    import tsd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_res,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_frame_kind,
    input logic [63:0] o_sequence_res,
    input logic [15:0] o_payload_length,
    input logic        o_last
);

    `ASSERT_CLK_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "output valid after reset")

    `ASSERT_CLK(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_event_res) && $stable(o_payload_byte) && $stable(o_sequence_res) && $stable(o_last)), "stalled result changed")

    `ASSERT_CLK(a_bad_len_clean, (o_out_valid && (o_event_res == EV_BAD_LEN)) |-> (o_last && (o_frame_kind == 8'd0) && (o_sequence_res == 64'd0) && (o_payload_length == 16'd0)), "bad length result carries frame context")

    `ASSERT_CLK(a_event_no_data, (o_out_valid && (o_event_res != EV_PAYLOAD)) |-> (o_last && (o_payload_byte == 8'd0)), "non-payload result not final or carries data")

endmodule

bind typed_sequenced_deframer tsd_checker u_tsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_event_res      (o_event_res),
    .o_payload_byte   (o_payload_byte),
    .o_frame_kind     (o_frame_kind),
    .o_sequence_res   (o_sequence_res),
    .o_payload_length (o_payload_length),
    .o_last           (o_last)
);

FILE: bench/deframe_checker.sv
// ----------------------------------------------------------------------------
// deframe_checker
// Predicts and checks the results of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// Watches the configuration, byte and result channels. It keeps its own copy
// of the parser state and the registers, works out the results of each
// accepted byte, and compares every accepted result field by field with the
// oldest one still waiting. It reports the failure count and the number of
// results still waiting.
module deframe_checker
    import tsd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [1:0]                i_event_res,
    input  logic [7:0]                i_payload_byte,
    input  logic [7:0]                i_frame_kind,
    input  logic [63:0]               i_sequence_res,
    input  logic [15:0]               i_payload_length,
    input  logic                      i_last,
    output int                        o_errors,
    output int                        o_outstanding
);

    typedef enum logic [1:0] {
        STAGE_PREFIX  = 2'd0,
        STAGE_HEADER  = 2'd1,
        STAGE_PAYLOAD = 2'd2
    } t_stage;

    // largest total length the payload counter can follow
    localparam logic [31:0] LENGTH_CAP = BODY_HEADER_BYTES + (2**PAYLOAD_COUNT_BITS) - 1;

    logic [7:0]  control_code;
    logic [7:0]  serial_code;
    logic [15:0] control_max;
    logic [15:0] serial_max;
    logic [16:0] frame_max;

    t_stage                        stage;
    logic [3:0]                    hdr_pos;
    logic [31:0]                   len_word;
    logic [7:0]                    type_held;
    logic                          hdr_fault;
    logic [63:0]                   seq_held;
    logic [PAYLOAD_COUNT_BITS-1:0] payload_left;

    t_cmd expected_events[$];
    int   errors = 0;

    task automatic add_result(input t_event ev, input logic [7:0] data,
                              input logic [7:0] typ, input logic [63:0] seq,
                              input logic [15:0] plen, input logic last);
        t_cmd item;
        item.ev         = ev;
        item.data       = data;
        item.kind       = typ;
        item.seq        = seq;
        item.plen       = plen;
        item.last       = last;
        expected_events.push_back(item);
    endtask

    // advance the parser by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [3:0]  pos;
        logic [31:0] body_len;
        logic [31:0] limit;
        logic        known;
        logic        done;
        case (stage)
            STAGE_HEADER: begin
                pos = hdr_pos;
                if (pos == 0) begin
                    type_held = b;
                end else if (pos <= 3) begin
                    if (b != 8'd0) hdr_fault = 1'b1;
                end else begin
                    seq_held = {seq_held[55:0], b};
                end
                hdr_pos = pos + 4'd1;
                if (hdr_pos >= BODY_HEADER_BYTES) begin
                    body_len = len_word - BODY_HEADER_BYTES;
                    known    = 1'b0;
                    hdr_pos  = 4'd0;
                    // equal codes: both limits apply
                    if (type_held == serial_code) begin
                        known = 1'b1;
                        if (body_len < 1 || body_len > serial_max) hdr_fault = 1'b1;
                    end
                    if (type_held == control_code) begin
                        known = 1'b1;
                        if (body_len > control_max) hdr_fault = 1'b1;
                    end
                    if (!known) hdr_fault = 1'b1;
                    if (body_len == 0) begin
                        stage = STAGE_PREFIX;
                        if (hdr_fault)
                            add_result(EV_BAD_HDR, 8'd0, type_held, seq_held, 16'd0, 1'b1);
                        else
                            add_result(EV_EMPTY, 8'd0, type_held, seq_held, 16'd0, 1'b1);
                    end else begin
                        payload_left = body_len[PAYLOAD_COUNT_BITS-1:0];
                        stage        = STAGE_PAYLOAD;
                    end
                end
            end
            STAGE_PAYLOAD: begin
                body_len     = len_word - BODY_HEADER_BYTES;
                payload_left = payload_left - 1'b1;
                done         = (payload_left == 0);
                if (done) stage = STAGE_PREFIX;
                // a faulty frame is swallowed and reported once on its last byte
                if (!hdr_fault)
                    add_result(EV_PAYLOAD, b, type_held, seq_held, body_len[15:0], done);
                else if (done)
                    add_result(EV_BAD_HDR, 8'd0, type_held, seq_held, body_len[15:0], 1'b1);
            end
            default: begin
                stage    = STAGE_PREFIX;
                len_word = {len_word[23:0], b};
                hdr_pos  = hdr_pos + 4'd1;
                if (hdr_pos >= PREFIX_BYTES) begin
                    hdr_pos = 4'd0;
                    limit   = frame_max;
                    if (limit > LENGTH_CAP) limit = LENGTH_CAP;
                    if (len_word < BODY_HEADER_BYTES || len_word > limit) begin
                        // resync: the next byte opens a new prefix
                        len_word = 32'd0;
                        add_result(EV_BAD_LEN, 8'd0, 8'd0, 64'd0, 16'd0, 1'b1);
                    end else begin
                        stage        = STAGE_HEADER;
                        type_held    = 8'd0;
                        hdr_fault    = 1'b0;
                        seq_held     = 64'd0;
                        payload_left = '0;
                    end
                end
            end
        endcase
    endtask

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_cmd want;
        if (!i_rst_n) begin
            control_code = RST_CONTROL_TYPE;
            serial_code  = RST_SERIAL_TYPE;
            control_max  = RST_CONTROL_MAX;
            serial_max   = RST_SERIAL_MAX;
            frame_max    = RST_FRAME_MAX;
            stage        = STAGE_PREFIX;
            hdr_pos      = 4'd0;
            len_word     = 32'd0;
            type_held    = 8'd0;
            hdr_fault    = 1'b0;
            seq_held     = 64'd0;
            payload_left = '0;
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CONTROL_TYPE: control_code = i_cfg_data[7:0];
                    CFG_SERIAL_TYPE:  serial_code  = i_cfg_data[7:0];
                    CFG_CONTROL_MAX:  control_max  = i_cfg_data[15:0];
                    CFG_SERIAL_MAX:   serial_max   = i_cfg_data[15:0];
                    CFG_FRAME_MAX:    frame_max    = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) deframe_byte(i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, expected nothing, got event %0d",
                             $time, i_event_res);
                end else begin
                    want = expected_events.pop_front();
                    compare_field("event",          want.ev,         i_event_res);
                    compare_field("payload byte",   want.data,       i_payload_byte);
                    compare_field("frame type",     want.kind,       i_frame_kind);
                    compare_field("sequence",       want.seq,        i_sequence_res);
                    compare_field("payload length", want.plen,       i_payload_length);
                    compare_field("last",           want.last,       i_last);
                end
            end
        end
        o_outstanding <= expected_events.size();
        o_errors      <= errors;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// Feeds well-formed frames with random content, bad length prefixes, frames
// with broken headers and raw noise, over several register settings from the
// low to the high extremes. Both the byte sender and the result receiver wait
// a random number of cycles per request, with stretches at full rate. The
// checker beside the block predicts and compares every result.
module tb;
    import tsd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [31:0] LENGTH_CAP = BODY_HEADER_BYTES + (2**PAYLOAD_COUNT_BITS) - 1;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic [7:0]                i_rx_byte   = 8'd0;
    logic                      i_out_ready = 1'b0;
    logic                      o_cfg_ready;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [1:0]                o_event_res;
    logic [7:0]                o_payload_byte;
    logic [7:0]                o_frame_kind;
    logic [63:0]               o_sequence_res;
    logic [15:0]               o_payload_length;
    logic                      o_last;

    int fail_count;
    int outstanding;
    int cycles     = 0;
    int bytes_sent = 0;
    int out_hold   = 0;
    bit in_burst   = 1'b0;
    bit out_burst  = 1'b0;

    // register values as last written, used to shape the frames
    logic [7:0]  control_code = RST_CONTROL_TYPE;
    logic [7:0]  serial_code  = RST_SERIAL_TYPE;
    logic [15:0] control_max  = RST_CONTROL_MAX;
    logic [15:0] serial_max   = RST_SERIAL_MAX;
    logic [16:0] frame_max    = RST_FRAME_MAX;

    always #10 i_clk = ~i_clk;

    typed_sequenced_deframer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_event_res      (o_event_res),
        .o_payload_byte   (o_payload_byte),
        .o_frame_kind     (o_frame_kind),
        .o_sequence_res   (o_sequence_res),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

    deframe_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_event_res      (o_event_res),
        .i_payload_byte   (o_payload_byte),
        .i_frame_kind     (o_frame_kind),
        .i_sequence_res   (o_sequence_res),
        .i_payload_length (o_payload_length),
        .i_last           (o_last),
        .o_errors         (fail_count),
        .o_outstanding    (outstanding)
    );

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic int body_limit();
        logic [31:0] lim;
        lim = (frame_max > LENGTH_CAP) ? LENGTH_CAP : 32'(frame_max);
        return int'(lim) - BODY_HEADER_BYTES;
    endfunction

    // result receiver: hold ready low for a random number of cycles per request
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold    <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
            hold = draw_wait(out_burst);
            out_hold    <= hold;
            i_out_ready <= (hold == 0);
        end else if (out_hold != 0) begin
            out_hold    <= out_hold - 1;
            i_out_ready <= (out_hold == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // valid stays high across back-to-back requests
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(in_burst);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_word32(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
    endtask

    task automatic send_frame(input logic [31:0] total, input logic [7:0] typ,
                              input logic [7:0] flags, input logic [15:0] rsvd,
                              input logic [63:0] seq, input int body);
        send_word32(total);
        send_byte(typ);
        send_byte(flags);
        send_byte(rsvd[15:8]);
        send_byte(rsvd[7:0]);
        for (int i = 7; i >= 0; i--) send_byte(seq[8*i +: 8]);
        repeat (body) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CONTROL_TYPE: control_code = data[7:0];
            CFG_SERIAL_TYPE:  serial_code  = data[7:0];
            CFG_CONTROL_MAX:  control_max  = data[15:0];
            CFG_SERIAL_MAX:   serial_max   = data[15:0];
            CFG_FRAME_MAX:    frame_max    = data[16:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] ct, input logic [7:0] st,
                                 input logic [15:0] cm, input logic [15:0] sm,
                                 input logic [16:0] fm);
        write_reg(CFG_CONTROL_TYPE, CFG_DATA_BITS'(ct));
        write_reg(CFG_SERIAL_TYPE,  CFG_DATA_BITS'(st));
        write_reg(CFG_CONTROL_MAX,  CFG_DATA_BITS'(cm));
        write_reg(CFG_SERIAL_MAX,   CFG_DATA_BITS'(sm));
        write_reg(CFG_FRAME_MAX,    fm);
        i_cfg_valid <= 1'b0;
    endtask

    // hold the sender until every expected result has come and the parser is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_frame();
        int          kind;
        int          body;
        int          lo;
        int          hi;
        int          lim_body;
        logic [7:0]  typ;
        logic [7:0]  flags;
        logic [15:0] rsvd;
        logic [63:0] seq;
        logic [31:0] total;
        in_burst = ($urandom_range(0, 3) == 0);
        lim_body = body_limit();
        kind     = $urandom_range(0, 99);
        flags    = 8'd0;
        rsvd     = 16'd0;
        seq      = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) seq = $urandom_range(0, 1) ? {64{1'b1}} : 64'd0;
        typ = $urandom_range(0, 1) ? serial_code : control_code;
        lo  = (typ == serial_code) ? 1 : 0;
        hi  = ($urandom_range(0, 9) == 0) ? 300 : 24;
        if (lim_body < hi) hi = lim_body;
        if (typ == serial_code && serial_max < hi) hi = serial_max;
        if (typ == control_code && control_max < hi) hi = control_max;
        if (hi < lo) body = lo;
        else if (lo == 0 && $urandom_range(0, 4) == 0) body = 0;
        else body = $urandom_range(lo, hi);

        if (kind < 55) begin
            send_frame(32'(body + BODY_HEADER_BYTES), typ, flags, rsvd, seq, body);
        end else if (kind < 70) begin
            case ($urandom_range(0, 2))
                0:       total = $urandom_range(0, BODY_HEADER_BYTES - 1);
                1:       total = 32'(lim_body + BODY_HEADER_BYTES + 1 + $urandom_range(0, 3));
                default: total = $urandom;
            endcase
            send_word32(total);
        end else if (kind < 85) begin
            body = $urandom_range(0, 12);
            if (body > lim_body) body = lim_body;
            case ($urandom_range(0, 4))
                0: begin
                    do typ = 8'($urandom_range(0, 255));
                    while (typ == control_code || typ == serial_code);
                end
                1: flags = 8'($urandom_range(1, 255));
                2: rsvd  = 16'($urandom_range(1, 65535));
                3: begin
                    typ  = serial_code;
                    body = 0;
                end
                default: begin
                    typ = control_code;
                    if (control_max < lim_body && control_max < 40) body = control_max + 1;
                    else flags = 8'h80;
                end
            endcase
            send_frame(32'(body + BODY_HEADER_BYTES), typ, flags, rsvd, seq, body);
        end else begin
            repeat ($urandom_range(1, 3)) send_word32($urandom);
        end
    endtask

    task automatic run_phase(input int n);
        int stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) random_frame();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero and all-ones length prefixes, then a good empty control frame
        send_word32(32'd0);
        send_word32({32{1'b1}});
        send_frame(BODY_HEADER_BYTES, control_code, 8'd0, 16'd0, {64{1'b1}}, 0);
        run_phase(350);

        // low extremes: only a total of exactly 12, then 13
        settle();
        load_settings(8'd0, 8'd255, 16'd0, 16'd1, 17'd12);
        run_phase(60);
        settle();
        load_settings(8'd0, 8'd255, 16'd0, 16'd1, 17'd13);
        run_phase(60);

        // high extremes: a length just past what the counter can follow
        settle();
        load_settings(8'd255, 8'd0, 16'd65535, 16'd65535, 17'd65547);
        in_burst = 1'b1;
        send_word32(LENGTH_CAP + 1);
        run_phase(250);

        // equal type codes, frame limit above what the counter can follow
        settle();
        load_settings(8'd7, 8'd7, 16'd20, 16'd8, {CFG_DATA_BITS{1'b1}});
        run_phase(200);

        settle();
        load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 40)), 16'($urandom_range(1, 40)),
                      17'($urandom_range(12, 80)));
        run_phase(200);

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: typed_sequenced_deframer.f
+incdir+src
src/tsd_pkg.sv
src/tsd_front.sv
src/tsd_queue.sv
src/tsd_back.sv
src/typed_sequenced_deframer.sv
src/tsd_checker.sv
bench/deframe_checker.sv
bench/tb.sv
